@@ rtl/texture_store_and_sampler_assert.svh @@
// Assertion macros for the RTL files; tss_ctrl.sv includes them.
`ifndef TEXTURE_STORE_AND_SAMPLER_ASSERT_SVH
`define TEXTURE_STORE_AND_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error("texture sampler check failed");
`define TSS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("texture sampler check failed");
`else
`define TSS_ASSERT(label, clk, rst_n, prop)
`define TSS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/tss_pkg.sv @@
`timescale 1ns / 1ps
package tss_pkg;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRC    = 2'd2;
  localparam logic [1:0] REG_STORE  = 2'd3;

  localparam logic [1:0] FILT_NEAREST  = 2'd0;
  localparam logic [1:0] FILT_BILINEAR = 2'd1;
  localparam logic [1:0] FILT_COSINE   = 2'd2;
  localparam logic [1:0] FILT_BLACK    = 2'd3;

  typedef struct packed {
    logic       load;
    logic       latch;
    logic       wcalc;
    logic       issue;
    logic [1:0] corner;
    logic       acc;
  } cmd_t;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [2:0] src;
    logic [2:0] store;
    logic       wr;
  } cfg_t;

  function automatic logic [16:0] cos_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd630;
      5'd2:  v = 17'd2494;
      5'd3:  v = 17'd5522;
      5'd4:  v = 17'd9598;
      5'd5:  v = 17'd14563;
      5'd6:  v = 17'd20228;
      5'd7:  v = 17'd26375;
      5'd8:  v = 17'd32768;
      5'd9:  v = 17'd39161;
      5'd10: v = 17'd45308;
      5'd11: v = 17'd50973;
      5'd12: v = 17'd55938;
      5'd13: v = 17'd60014;
      5'd14: v = 17'd63042;
      5'd15: v = 17'd64906;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/texture_store_and_sampler.sv @@
`timescale 1ns / 1ps
// Texture store and sampler.
// A command is taken when start is high and busy is low. With mode 0 the item
// is a pixel load: it is converted to the stored channel count and written at
// the load pointer in the same cycle, and the next command may follow at once.
// With mode 1 the item is a sample at fixed-point x,y by the chosen filter.
// A sample passes from the transfer to the result strobe through the filter
// weights, the four neighbor reads through the single read port of the pixel
// memory, a step that finishes the accumulation and a step that shows the
// result. valid_o marks the result for one cycle and the receiver cannot stall
// it; a new command may be taken in that same cycle.
// The user must write configuration over the APB port only while the block
// is idle; the block does not enforce this. Any write rewinds the load pointer.
// Reset sets register defaults and a zero load pointer; pixel memory is kept.
module texture_store_and_sampler #(
  parameter int MAX_PIXELS      = 65536,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [7:0]  pix_c0_i,
  input  logic [7:0]  pix_c1_i,
  input  logic [7:0]  pix_c2_i,
  input  logic [7:0]  pix_c3_i,
  input  logic [17:0] sample_x_i,
  input  logic [17:0] sample_y_i,
  input  logic [1:0]  filter_kind_i,
  output logic        valid_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tss_pkg::*;

  logic [8:0] width_q, height_q;
  logic [2:0] src_q, store_q;
  logic       wr;
  cfg_t       cfg;
  cmd_t       cmd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd1;
      height_q <= 9'd1;
      src_q    <= 3'd4;
      store_q  <= 3'd0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[8:0];
        REG_HEIGHT: height_q <= pwdata[8:0];
        REG_SRC:    src_q    <= pwdata[2:0];
        REG_STORE:  store_q  <= pwdata[2:0];
        default:    width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_SRC:    prdata = 32'(src_q);
      REG_STORE:  prdata = 32'(store_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.wr     = wr;
    cfg.width  = (width_q == 9'd0) ? 9'd1 : ((width_q > 9'd256) ? 9'd256 : width_q);
    cfg.height = (height_q == 9'd0) ? 9'd1 : ((height_q > 9'd256) ? 9'd256 : height_q);
    cfg.src    = (src_q == 3'd0) ? 3'd1 : ((src_q > 3'd4) ? 3'd4 : src_q);
    if (store_q == 3'd0) begin
      cfg.store = cfg.src;
    end else begin
      cfg.store = (store_q > 3'd4) ? 3'd4 : store_q;
    end
  end

  tss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .mode_i  (mode_i),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  tss_dp #(
    .MAX_PIXELS      (MAX_PIXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .pix_c0_i      (pix_c0_i),
    .pix_c1_i      (pix_c1_i),
    .pix_c2_i      (pix_c2_i),
    .pix_c3_i      (pix_c3_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .filter_kind_i (filter_kind_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_alpha_o   (out_alpha_o)
  );

endmodule

@@ rtl/tss_ctrl.sv @@
`timescale 1ns / 1ps
`include "texture_store_and_sampler_assert.svh"
module tss_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          mode_i,
  output logic          busy,
  output logic          valid_o,
  output tss_pkg::cmd_t cmd_o
);
  import tss_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WGT   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_LAST  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;

  assign accept  = start && !busy;
  assign busy    = !(state_q == ST_IDLE || state_q == ST_OUT);
  assign valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.load   = accept && !mode_i;
    cmd_o.latch  = accept && mode_i;
    cmd_o.corner = cnt_q;
    case (state_q)
      ST_IDLE, ST_OUT: begin
        if (accept && mode_i) begin
          state_d = ST_WGT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WGT: begin
        cmd_o.wcalc = 1'b1;
        cnt_d       = 2'd0;
        state_d     = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        cmd_o.acc   = (cnt_q != 2'd0);
        cnt_d       = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `TSS_ASSERT(a_sample_busy, clk_i, rst_ni, (start && !busy && mode_i) |=> busy)
  `TSS_ASSERT(a_strobe_single, clk_i, rst_ni, valid_o |=> !valid_o)
  `TSS_ASSERT(a_last_then_out, clk_i, rst_ni, (state_q == ST_LAST) |=> valid_o)
  `TSS_ASSERT(a_issue_corner, clk_i, rst_ni,
              (state_q == ST_WGT) |=> (state_q == ST_ISSUE && cnt_q == 2'd0))

endmodule

@@ rtl/tss_dp.sv @@
`timescale 1ns / 1ps
module tss_dp #(
  parameter int MAX_PIXELS      = 65536,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tss_pkg::cmd_t cmd_i,
  input  tss_pkg::cfg_t cfg_i,
  input  logic [7:0]    pix_c0_i,
  input  logic [7:0]    pix_c1_i,
  input  logic [7:0]    pix_c2_i,
  input  logic [7:0]    pix_c3_i,
  input  logic [17:0]   sample_x_i,
  input  logic [17:0]   sample_y_i,
  input  logic [1:0]    filter_kind_i,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic [7:0]    out_alpha_o
);
  import tss_pkg::*;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [31:0] mem [MAX_PIXELS];

  logic [ADDR_W-1:0] lp_q;
  logic signed [17:0] sx_q, sy_q;
  logic [1:0]  kind_q;
  logic [16:0] wx_q, wy_q;
  logic [32:0] w_q;
  logic        oob_q, beyond_q;
  logic [31:0] rd_q;
  logic [40:0] acc_q [4];

  logic [7:0]  src [4];
  logic [31:0] wr_word;
  logic [15:0] tx, ty;
  logic [16:0] cwx, cwy;
  logic signed [17:0] xi, yi;
  logic signed [18:0] xc, yc;
  logic        oob;
  logic [16:0] idx;
  logic [20:0] idx_ext;
  logic        beyond;
  logic [16:0] wxs, wys;
  logic [33:0] wprod;
  logic [31:0] word;
  logic [7:0]  ch [4];
  logic [7:0]  res [4];
  logic [40:0] rnd;

  function automatic logic [16:0] cos_w(input logic [15:0] t);
    logic [16:0] lo, hi, d;
    logic [27:0] p;
    lo = cos_tab({1'b0, t[15:12]});
    hi = cos_tab({1'b0, t[15:12]} + 5'd1);
    d  = hi - lo;
    p  = 28'(d) * 28'(t[11:0]) + 28'd2048;
    return lo + 17'(p[27:12]);
  endfunction

  assign src[0] = pix_c0_i;
  assign src[1] = pix_c1_i;
  assign src[2] = pix_c2_i;
  assign src[3] = pix_c3_i;

  always_comb begin
    wr_word = '0;
    for (int c = 0; c < 4; c++) begin
      if (3'(c) < cfg_i.store) begin
        if (3'(c) < cfg_i.src) begin
          wr_word[8*c +: 8] = src[c];
        end else if (c < 3) begin
          wr_word[8*c +: 8] = src[2'(cfg_i.src - 3'd1)];
        end else begin
          wr_word[8*c +: 8] = 8'hFF;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (cfg_i.wr) begin
      lp_q <= '0;
    end else if (cmd_i.load) begin
      if (32'(lp_q) == MAX_PIXELS - 1) begin
        lp_q <= '0;
      end else begin
        lp_q <= lp_q + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    tx  = 16'(sx_q[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
    ty  = 16'(sy_q[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
    cwx = '0;
    cwy = '0;
    case (kind_q)
      FILT_BILINEAR: begin
        cwx = 17'(tx);
        cwy = 17'(ty);
      end
      FILT_COSINE: begin
        cwx = cos_w(tx);
        cwy = cos_w(ty);
      end
      default: begin
        cwx = '0;
        cwy = '0;
      end
    endcase
  end

  always_comb begin
    xi      = sx_q >>> COORD_FRAC_BITS;
    yi      = sy_q >>> COORD_FRAC_BITS;
    xc      = 19'(xi) + 19'(cmd_i.corner[0]);
    yc      = 19'(yi) + 19'(cmd_i.corner[1]);
    oob     = (kind_q == FILT_BLACK) || xc[18] || yc[18] ||
              (xc[17:0] >= 18'(cfg_i.width)) || (yc[17:0] >= 18'(cfg_i.height));
    idx     = 17'(yc[7:0]) * 17'(cfg_i.width) + 17'(xc[7:0]);
    idx_ext = 21'(idx);
    beyond  = 32'(idx_ext) >= MAX_PIXELS;
    wxs     = cmd_i.corner[0] ? wx_q : 17'd65536 - wx_q;
    wys     = cmd_i.corner[1] ? wy_q : 17'd65536 - wy_q;
    wprod   = 34'(wxs) * 34'(wys);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[lp_q] <= wr_word;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[idx_ext[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sx_q   <= sample_x_i;
      sy_q   <= sample_y_i;
      kind_q <= filter_kind_i;
    end
    if (cmd_i.wcalc) begin
      wx_q <= cwx;
      wy_q <= cwy;
    end
    if (cmd_i.issue) begin
      w_q      <= wprod[32:0];
      oob_q    <= oob;
      beyond_q <= beyond;
    end
  end

  always_comb begin
    word = beyond_q ? 32'd0 : rd_q;
    for (int c = 0; c < 4; c++) begin
      if (oob_q) begin
        ch[c] = (c == 3) ? 8'hFF : 8'h00;
      end else if (3'(c) < cfg_i.store) begin
        ch[c] = word[8*c +: 8];
      end else begin
        ch[c] = (c == 3) ? 8'hFF : 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      if (cmd_i.latch) begin
        acc_q[c] <= '0;
      end else if (cmd_i.acc) begin
        acc_q[c] <= acc_q[c] + 41'(ch[c]) * 41'(w_q);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd    = acc_q[c] + 41'h0_8000_0000;
      res[c] = (rnd[40:32] > 9'd255) ? 8'hFF : rnd[39:32];
    end
  end

  assign out_red_o   = res[0];
  assign out_green_o = res[1];
  assign out_blue_o  = res[2];
  assign out_alpha_o = res[3];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import tss_pkg::*;

  typedef struct {
    logic        mode;
    logic [7:0]  c0, c1, c2, c3;
    logic [17:0] sx, sy;
    logic [1:0]  filt;
  } tex_cmd_t;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic        mode_i;
  logic [7:0]  pix_c0_i, pix_c1_i, pix_c2_i, pix_c3_i;
  logic [17:0] sample_x_i, sample_y_i;
  logic [1:0]  filter_kind_i;
  logic        valid_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  texture_store_and_sampler u_top (.*);

  tex_cmd_t    cmd_q[$];
  rgba_t       color_q[$];
  logic [31:0] texel_mem [65536];
  int unsigned load_ptr;
  int unsigned w_reg, h_reg, src_reg, store_reg;
  int          errors, n_loads, n_samples, gap_left, burst_cnt;

  localparam int unsigned COS_LUT [17] = '{0, 630, 2494, 5522, 9598, 14563, 20228, 26375,
    32768, 39161, 45308, 50973, 55938, 60014, 63042, 64906, 65536};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    return (v == 0) ? 1 : ((v > 256) ? 256 : v);
  endfunction

  function automatic int unsigned src_count();
    return (src_reg == 0) ? 1 : ((src_reg > 4) ? 4 : src_reg);
  endfunction

  function automatic int unsigned kept_count();
    if (store_reg == 0) return src_count();
    return (store_reg > 4) ? 4 : store_reg;
  endfunction

  function automatic void read_texel(longint x, longint y, output int unsigned ch[4]);
    longint w, h;
    logic [31:0] word;
    int unsigned m;
    w = clamp_dim(w_reg);
    h = clamp_dim(h_reg);
    m = kept_count();
    if (x < 0 || y < 0 || x >= w || y >= h) begin
      ch = '{0, 0, 0, 255};
      return;
    end
    word = (y * w + x < 65536) ? texel_mem[y * w + x] : 32'd0;
    for (int c = 0; c < 4; c++)
      ch[c] = (c < m) ? word[8*c +: 8] : ((c == 3) ? 255 : 0);
  endfunction

  function automatic longint unsigned cos_ramp(int unsigned t);
    int unsigned i, r, lo, hi;
    i = t >> 12;
    r = t & 32'hFFF;
    lo = COS_LUT[i];
    hi = COS_LUT[i + 1];
    return lo + (((hi - lo) * r + 2048) >> 12);
  endfunction

  function automatic rgba_t filter_texels(tex_cmd_t t);
    int          sx, sy;
    longint      xi, yi;
    int unsigned fx, fy, res[4], c00[4], c10[4], c01[4], c11[4];
    longint unsigned wx, wy, r0, r1, acc;
    rgba_t       o;
    sx = $signed(t.sx);
    sy = $signed(t.sy);
    fx = sx & 255;
    fy = sy & 255;
    xi = sx >>> 8;
    yi = sy >>> 8;
    if (t.filt == FILT_NEAREST) begin
      read_texel(xi, yi, res);
    end else if (t.filt != FILT_BILINEAR && t.filt != FILT_COSINE) begin
      res = '{0, 0, 0, 255};
    end else begin
      read_texel(xi, yi, c00);
      read_texel(xi + 1, yi, c10);
      read_texel(xi, yi + 1, c01);
      read_texel(xi + 1, yi + 1, c11);
      wx = fx << 8;
      wy = fy << 8;
      if (t.filt == FILT_COSINE) begin
        wx = cos_ramp(fx << 8);
        wy = cos_ramp(fy << 8);
      end
      for (int c = 0; c < 4; c++) begin
        r0 = c00[c] * (65536 - wx) + c10[c] * wx;
        r1 = c01[c] * (65536 - wx) + c11[c] * wx;
        acc = (r0 * (65536 - wy) + r1 * wy + 64'h8000_0000) >> 32;
        res[c] = (acc > 255) ? 255 : acc;
      end
    end
    o.r = res[0]; o.g = res[1]; o.b = res[2]; o.a = res[3];
    return o;
  endfunction

  function automatic void apply_cmd(tex_cmd_t t);
    int unsigned s, m, src[4], v;
    logic [31:0] word;
    if (t.mode) begin
      color_q.push_back(filter_texels(t));
      n_samples++;
      return;
    end
    s = src_count();
    m = kept_count();
    src = '{t.c0, t.c1, t.c2, t.c3};
    word = '0;
    for (int c = 0; c < m; c++) begin
      if (c < s) v = src[c];
      else if (c < 3) v = src[s - 1];
      else v = 255;
      word[8*c +: 8] = 8'(v);
    end
    texel_mem[load_ptr] = word;
    load_ptr = (load_ptr + 1 >= 65536) ? 0 : load_ptr + 1;
    n_loads++;
  endfunction

  function automatic int pick_gap();
    int p;
    if (burst_cnt < 40) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      mode_i <= 1'b0;
      pix_c0_i <= '0; pix_c1_i <= '0; pix_c2_i <= '0; pix_c3_i <= '0;
      sample_x_i <= '0; sample_y_i <= '0; filter_kind_i <= '0;
      gap_left = 0;
      burst_cnt = 0;
    end else begin
      if (start && !busy) begin
        apply_cmd(cmd_q[0]);
        cmd_q.pop_front();
        burst_cnt = (burst_cnt + 1) % 100;
        gap_left = pick_gap();
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        start <= 1'b1;
        mode_i <= cmd_q[0].mode;
        pix_c0_i <= cmd_q[0].c0; pix_c1_i <= cmd_q[0].c1;
        pix_c2_i <= cmd_q[0].c2; pix_c3_i <= cmd_q[0].c3;
        sample_x_i <= cmd_q[0].sx; sample_y_i <= cmd_q[0].sy;
        filter_kind_i <= cmd_q[0].filt;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (color_q.size() == 0) begin
        $error("result transfer with no sample pending");
        errors++;
      end else begin
        if (out_red_o !== color_q[0].r) begin
          $error("out_red expected %0d actual %0d", color_q[0].r, out_red_o); errors++;
        end
        if (out_green_o !== color_q[0].g) begin
          $error("out_green expected %0d actual %0d", color_q[0].g, out_green_o); errors++;
        end
        if (out_blue_o !== color_q[0].b) begin
          $error("out_blue expected %0d actual %0d", color_q[0].b, out_blue_o); errors++;
        end
        if (out_alpha_o !== color_q[0].a) begin
          $error("out_alpha expected %0d actual %0d", color_q[0].a, out_alpha_o); errors++;
        end
        color_q.pop_front();
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, int unsigned val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  w_reg = val & 32'h1FF;
      REG_HEIGHT: h_reg = val & 32'h1FF;
      REG_SRC:    src_reg = val & 7;
      default:    store_reg = val & 7;
    endcase
    load_ptr = 0;
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || color_q.size() != 0 || start) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic tex_cmd_t make_sample(int x, int y, logic [1:0] f);
    tex_cmd_t t;
    t.mode = 1'b1;
    t.c0 = 8'($urandom); t.c1 = 8'($urandom); t.c2 = 8'($urandom); t.c3 = 8'($urandom);
    t.sx = 18'(x); t.sy = 18'(y); t.filt = f;
    return t;
  endfunction

  function automatic int rand_coord(int unsigned dim);
    if ($urandom_range(0, 4) == 0) return $signed(18'($urandom));
    return $urandom_range(0, (dim + 2) * 256 - 1) - 256;
  endfunction

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned s, int unsigned k,
                           int unsigned extra_loads, int n_rand, bit directed);
    tex_cmd_t t;
    int unsigned ew, eh, n;
    wait_idle();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_SRC, s);
    apb_write(REG_STORE, k);
    ew = clamp_dim(w);
    eh = clamp_dim(h);
    n = ew * eh;
    @(negedge clk_i);
    for (int unsigned i = 0; i < n + extra_loads; i++) begin
      t.mode = 1'b0;
      t.c0 = 8'($urandom); t.c1 = 8'($urandom); t.c2 = 8'($urandom); t.c3 = 8'($urandom);
      t.sx = 18'($urandom); t.sy = 18'($urandom); t.filt = 2'($urandom);
      cmd_q.push_back(t);
    end
    if (directed) begin
      for (int f = 0; f < 4; f++) begin
        cmd_q.push_back(make_sample(0, 0, 2'(f)));
        cmd_q.push_back(make_sample((ew - 1) * 256 + 255, (eh - 1) * 256 + 255, 2'(f)));
        cmd_q.push_back(make_sample(131071, -131072, 2'(f)));
        cmd_q.push_back(make_sample(-1, 128, 2'(f)));
      end
      cmd_q.push_back(make_sample(255, 255, FILT_COSINE));
      cmd_q.push_back(make_sample(-131072, 131071, FILT_BILINEAR));
    end
    for (int i = 0; i < n_rand; i++)
      cmd_q.push_back(make_sample(rand_coord(ew), rand_coord(eh), 2'($urandom)));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_loads = 0; n_samples = 0; load_ptr = 0;
    w_reg = 1; h_reg = 1; src_reg = 4; store_reg = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(4, 3, 3, 0, 0, 60, 1'b1);
    run_phase(1, 1, 1, 4, 0, 40, 1'b0);
    run_phase(0, 0, 0, 7, 0, 40, 1'b0);
    run_phase(7, 5, 2, 3, 0, 80, 1'b0);
    run_phase(12, 6, 4, 1, 0, 80, 1'b0);
    run_phase(300, 1, 5, 2, 3, 60, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (color_q.size() != 0) begin
      $error("%0d expected samples never returned", color_q.size());
      errors++;
    end
    $display("Run covered %0d pixel loads and %0d samples over six register settings,",
             n_loads, n_samples);
    $display("including a width clamped to 256 pixels and out-of-range register values.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

endmodule
